[design/bra_pkg.sv]
package bra_pkg;

   // map geometry
   localparam int MAP_BYTES = 128;
   localparam int ADDR_W    = $clog2(MAP_BYTES);
   localparam int BYTE_W    = 8;
   localparam int BIT_SEL_W = $clog2(BYTE_W);
   localparam int MNG_W     = $clog2(MAP_BYTES + 1);
   localparam int LIM_W     = MNG_W + BIT_SEL_W;

   // field widths
   localparam int OP_W   = 2;
   localparam int LEN_W  = 11;
   localparam int IDX_W  = 10;
   localparam int CSR_W  = 8;

   localparam logic [CSR_W-1:0] CSR_BYTES_RESET = CSR_W'(128);

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_SCAN  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   // map memory access
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } ram_req_type;

   // run counter control
   typedef struct packed {
      logic init;
      logic step;
   } scan_ctl_type;

   // run counter outcome for the current byte
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] start_index;
   } scan_hit_type;

endpackage

[design/bra_map_ram.sv]
module bra_map_ram (
   input  logic                                clock,
   input  logic                                reset,
   input  bra_pkg::ram_req_type                req,
   output logic [bra_pkg::BYTE_W-1:0]          rd_data
);

   logic [bra_pkg::BYTE_W-1:0] mem [bra_pkg::MAP_BYTES];
   logic [bra_pkg::MAP_BYTES-1:0] valid_ff;
   logic [bra_pkg::MAP_BYTES-1:0] valid_in;
   logic [bra_pkg::BYTE_W-1:0] rd_data_ff;

   // per-byte valid bits, an invalid byte reads as all free
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // byte storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= valid_ff[req.rd_addr] ? mem[req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bra_run_scan.sv]
module bra_run_scan (
   input  logic                                clock,
   input  bra_pkg::scan_ctl_type               ctl,
   input  logic [bra_pkg::LEN_W-1:0]           run_length,
   input  logic [bra_pkg::ADDR_W-1:0]          byte_addr,
   input  logic [bra_pkg::BYTE_W-1:0]          byte_data,
   output bra_pkg::scan_hit_type               result
);

   logic [bra_pkg::LEN_W-1:0]     count_ff;
   logic [bra_pkg::LEN_W-1:0]     count_in;
   logic [bra_pkg::LEN_W-1:0]     cnt;
   logic [bra_pkg::BIT_SEL_W-1:0] pos;
   logic                          hit;
   logic [bra_pkg::LEN_W-1:0]     start_sum;

   // walk the eight bits of one byte, lowest bit first
   always_comb begin
      cnt = count_ff;
      hit = 1'b0;
      pos = '0;
      for (int j = 0; j < bra_pkg::BYTE_W; j++) begin
         if (!hit) begin
            if (byte_data[j]) begin
               cnt = '0;
            end else begin
               cnt = cnt + bra_pkg::LEN_W'(1);
               if (cnt == run_length) begin
                  hit = 1'b1;
                  pos = bra_pkg::BIT_SEL_W'(j);
               end
            end
         end
      end
   end

   // first bit of the run that ends at the hit position
   assign start_sum = bra_pkg::LEN_W'({byte_addr, pos}) + bra_pkg::LEN_W'(1) - run_length;

   assign result.hit         = hit;
   assign result.start_index = start_sum[bra_pkg::IDX_W-1:0];

   // free-bit count carried from byte to byte
   always_comb begin
      count_in = count_ff;
      if (ctl.init) begin
         count_in = '0;
      end else if (ctl.step) begin
         count_in = cnt;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

endmodule

[design/bitmap_run_allocator_unit.sv]
// First-fit allocation bitmap of up to 1024 bits, held one byte per entry in a
// synchronous memory. An operation is taken when start is high and busy is low.
// Clear-all is done on acceptance, without leaving idle; a bit write reads the
// byte, then writes it back. A scan reads one map byte per cycle through the
// memory read port and checks its eight bits against the running free count,
// and ends at the last managed byte or early at the first fitting run; a zero
// run length or an empty map is answered as a miss without a scan.
// The scan answer sits on rsp_found and rsp_start_index for exactly one cycle,
// marked by rsp_valid, in the cycle after the scan ends; the receiver cannot
// stall it and must take it in that cycle. Clear and write give no answer.
// The csr_ register may be written only while busy is low and no answer is due.
module bitmap_run_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [bra_pkg::OP_W-1:0]           req_opcode,
   input  logic [bra_pkg::LEN_W-1:0]          req_run_length,
   input  logic [bra_pkg::IDX_W-1:0]          req_bit_index,
   input  logic                               req_bit_value,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [bra_pkg::IDX_W-1:0]          rsp_start_index,
   input  logic                               csr_wr_en,
   input  logic [bra_pkg::CSR_W-1:0]          csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [bra_pkg::CSR_W-1:0]        csr_bytes_ff, csr_bytes_in;
   logic [bra_pkg::MNG_W-1:0]        managed;
   logic [bra_pkg::LIM_W-1:0]        limit_bits;
   logic                             accept;
   logic                             in_range;

   logic [bra_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [bra_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [bra_pkg::BIT_SEL_W-1:0]    bit_sel_ff, bit_sel_in;
   logic                             bit_value_ff, bit_value_in;
   logic                             last_byte;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [bra_pkg::IDX_W-1:0]        rsp_start_ff, rsp_start_in;

   bra_pkg::ram_req_type             ram_req;
   logic [bra_pkg::BYTE_W-1:0]       ram_data;
   logic [bra_pkg::BYTE_W-1:0]       bit_mask;
   bra_pkg::scan_ctl_type            scan_ctl;
   bra_pkg::scan_hit_type            scan_hit;

   // configuration register
   always_comb begin
      csr_bytes_in = csr_bytes_ff;
      if (csr_wr_en) begin
         csr_bytes_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_bytes_ff <= bra_pkg::CSR_BYTES_RESET;
      end else begin
         csr_bytes_ff <= csr_bytes_in;
      end
   end

   // managed bytes, clamped to the map size
   always_comb begin
      if (int'(csr_bytes_ff) > bra_pkg::MAP_BYTES) begin
         managed = bra_pkg::MNG_W'(bra_pkg::MAP_BYTES);
      end else begin
         managed = bra_pkg::MNG_W'(csr_bytes_ff);
      end
   end

   assign limit_bits = {managed, bra_pkg::BIT_SEL_W'(0)};
   assign in_range   = bra_pkg::LIM_W'(req_bit_index) < limit_bits;
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign last_byte  = (bra_pkg::MNG_W'(addr_ff) == managed - bra_pkg::MNG_W'(1));
   assign bit_mask   = bra_pkg::BYTE_W'(1) << bit_sel_ff;

   // operation sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      bit_sel_in   = bit_sel_ff;
      bit_value_in = bit_value_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_start_in = '0;
      ram_req      = '0;
      scan_ctl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  bra_pkg::OP_CLEAR: begin
                     ram_req.clear = 1'b1;
                  end
                  bra_pkg::OP_WRITE: begin
                     if (in_range) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = bra_pkg::ADDR_W'(req_bit_index >> bra_pkg::BIT_SEL_W);
                        addr_in         = bra_pkg::ADDR_W'(req_bit_index >> bra_pkg::BIT_SEL_W);
                        bit_sel_in      = req_bit_index[bra_pkg::BIT_SEL_W-1:0];
                        bit_value_in    = req_bit_value;
                        state_in        = ST_WRITE;
                     end
                  end
                  bra_pkg::OP_SCAN: begin
                     if (req_run_length == '0 || managed == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = '0;
                        addr_in         = '0;
                        len_in          = req_run_length;
                        scan_ctl.init   = 1'b1;
                        state_in        = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRITE: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = addr_ff;
            ram_req.wr_data = bit_value_ff ? (ram_data | bit_mask) : (ram_data & ~bit_mask);
            state_in        = ST_IDLE;
         end
         ST_SCAN: begin
            scan_ctl.step = 1'b1;
            if (scan_hit.hit) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_start_in = scan_hit.start_index;
               state_in     = ST_IDLE;
            end else if (last_byte) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = addr_ff + bra_pkg::ADDR_W'(1);
               addr_in         = addr_ff + bra_pkg::ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operand and result word registers
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      addr_ff      <= addr_in;
      bit_sel_ff   <= bit_sel_in;
      bit_value_ff <= bit_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_start_index = rsp_start_ff;

   // map storage
   bra_map_ram u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .req     (ram_req),
      .rd_data (ram_data)
   );

   // free run counter
   bra_run_scan u_run_scan (
      .clock      (clock),
      .ctl        (scan_ctl),
      .run_length (len_ff),
      .byte_addr  (addr_ff),
      .byte_data  (ram_data),
      .result     (scan_hit)
   );

`ifndef SYNTHESIS
   // the write-back state of a read-modify-write always returns to idle next
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |=> state_ff == ST_IDLE)
      else $error("write state did not return to idle");

   // the scanned byte never leaves the managed part of the map
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> bra_pkg::MNG_W'(addr_ff) < managed)
      else $error("scan address beyond managed bytes");

   // a found run lies wholly inside the managed bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         (bra_pkg::LIM_W'(rsp_start_index) + bra_pkg::LIM_W'(len_ff)) <= limit_bits)
      else $error("found run exceeds managed bits");

   // a miss always reports start index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_start_index == '0)
      else $error("miss with nonzero start index");

   // an answer follows only a scan cycle or a scan taken in idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SCAN || (accept && req_opcode == bra_pkg::OP_SCAN)))
      else $error("answer without a scan");
`endif

endmodule
